// ===== hw/rtl/modular_inverse_extended_gcd_core_assert.svh =====
// ----------------------------------------------------------------------------
// Modular inverse core assertion macros
// Shared concurrent assertion forms for the controller and the datapath.
// ----------------------------------------------------------------------------
`ifndef MODULAR_INVERSE_EXTENDED_GCD_CORE_ASSERT_SVH
`define MODULAR_INVERSE_EXTENDED_GCD_CORE_ASSERT_SVH

// same-cycle implication, disabled during reset
`define MIEG_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled during reset
`define MIEG_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/mieg_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Modular inverse package
// Shared constants, controller states and command/status bundles.
// ----------------------------------------------------------------------------
package mieg_pkg;

    localparam int P_WIDTH = 32;

    typedef enum logic [2:0] {
        S_IDLE,
        S_TEST,
        S_DIV,
        S_UPD,
        S_DONE
    } t_state;

    typedef struct packed {
        logic load;
        logic div_start;
        logic div_step;
        logic update;
        logic finish;
    } t_cmd;

    typedef struct packed {
        logic newer_zero;
        logic div_last;
        logic out_free;
    } t_status;

endpackage

// ===== hw/rtl/mieg_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Modular inverse controller
// Sequences load, Euclid division steps, coefficient update and output.
// ----------------------------------------------------------------------------
`include "modular_inverse_extended_gcd_core_assert.svh"

module mieg_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  mieg_pkg::t_status i_status,
    output mieg_pkg::t_cmd    o_cmd
);
    import mieg_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) n_state = S_TEST;
            end
            S_TEST: begin
                n_state = i_status.newer_zero ? S_DONE : S_DIV;
            end
            S_DIV: begin
                if (i_status.div_last) n_state = S_UPD;
            end
            S_UPD: begin
                n_state = S_TEST;
            end
            S_DONE: begin
                if (i_status.out_free) n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_in_ready = 1'b0;
        o_cmd      = '0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            S_TEST: begin
                o_cmd.div_start = !i_status.newer_zero;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
            end
            S_UPD: begin
                o_cmd.update = 1'b1;
            end
            S_DONE: begin
                o_cmd.finish = i_status.out_free;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

    `MIEG_ASSERT_NXT(a_accept_to_test, i_clk, i_rst_n, i_in_valid && o_in_ready, r_state == S_TEST, "accepted word did not start a test")
    `MIEG_ASSERT_NXT(a_div_holds, i_clk, i_rst_n, r_state == S_DIV && !i_status.div_last, r_state == S_DIV, "division left early")
    `MIEG_ASSERT_IMP(a_finish_free, i_clk, i_rst_n, o_cmd.finish, i_status.out_free && r_state == S_DONE, "finish while output busy")

endmodule

// ===== hw/rtl/mieg_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Modular inverse datapath
// Restoring divider with quotient-times-coefficient accumulation, Euclid
// pair and coefficient registers, final reduction and output register.
// ----------------------------------------------------------------------------
`include "modular_inverse_extended_gcd_core_assert.svh"

module mieg_dp #(
    parameter int WIDTH = mieg_pkg::P_WIDTH
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [WIDTH-2:0]  i_cfg_wdata,
    input  logic [WIDTH-2:0]  i_value,
    input  mieg_pkg::t_cmd    i_cmd,
    output mieg_pkg::t_status o_status,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic [WIDTH-2:0]  o_inverse,
    output logic              o_has_inverse
);
    import mieg_pkg::*;

    localparam int OPW   = WIDTH - 1;
    localparam int CNT_W = $clog2(OPW);

    logic [OPW-1:0]   r_modulus;
    logic [OPW-1:0]   r_older;
    logic [OPW-1:0]   r_newer;
    logic [WIDTH-1:0] r_c_old;
    logic [WIDTH-1:0] r_c_new;
    logic [OPW-1:0]   r_rem;
    logic [OPW-1:0]   r_dvd;
    logic [WIDTH-1:0] r_acc;
    logic [CNT_W-1:0] r_cnt;
    logic             r_out_valid;
    logic [OPW-1:0]   r_inverse;
    logic             r_has_inverse;

    logic [OPW:0]     shifted;
    logic [OPW:0]     diff;
    logic             qbit;
    logic [WIDTH-1:0] n_acc;
    logic [WIDTH-1:0] y;
    logic [WIDTH-1:0] m_ext;
    logic [WIDTH-1:0] n_y;

    assign shifted = {r_rem, r_dvd[OPW-1]};
    assign diff    = shifted - {1'b0, r_newer};
    assign qbit    = !diff[OPW];
    assign n_acc   = {r_acc[WIDTH-2:0], 1'b0} + (qbit ? r_c_new : '0);

    assign y     = r_c_old;
    assign m_ext = {1'b0, r_modulus};
    always_comb begin
        n_y = y;
        if (r_modulus != '0) begin
            if (y[WIDTH-1]) begin
                n_y = y + m_ext;
            end else if (y >= m_ext) begin
                n_y = y - m_ext;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_modulus   <= OPW'(1);
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) r_modulus <= i_cfg_wdata;
            if (i_cmd.finish) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_older <= r_modulus;
            r_newer <= i_value;
            r_c_old <= '0;
            r_c_new <= WIDTH'(1);
        end
        if (i_cmd.div_start) begin
            r_dvd <= r_older;
            r_rem <= '0;
            r_acc <= '0;
            r_cnt <= '0;
        end
        if (i_cmd.div_step) begin
            r_rem <= qbit ? diff[OPW-1:0] : shifted[OPW-1:0];
            r_dvd <= {r_dvd[OPW-2:0], 1'b0};
            r_acc <= n_acc;
            r_cnt <= r_cnt + 1'b1;
        end
        if (i_cmd.update) begin
            r_older <= r_newer;
            r_newer <= r_rem;
            r_c_old <= r_c_new;
            r_c_new <= r_c_old - r_acc;
        end
        if (i_cmd.finish) begin
            r_inverse     <= n_y[OPW-1:0];
            r_has_inverse <= (r_older == OPW'(1));
        end
    end

    assign o_status.newer_zero = (r_newer == '0);
    assign o_status.div_last   = (r_cnt == CNT_W'(OPW - 1));
    assign o_status.out_free   = !r_out_valid || i_out_ready;

    assign o_out_valid   = r_out_valid;
    assign o_inverse     = r_inverse;
    assign o_has_inverse = r_has_inverse;

    `MIEG_ASSERT_IMP(a_div_nonzero, i_clk, i_rst_n, i_cmd.div_step, r_newer != '0, "division by zero")
    `MIEG_ASSERT_NXT(a_finish_valid, i_clk, i_rst_n, i_cmd.finish, r_out_valid, "finish did not raise valid")
    `MIEG_ASSERT_IMP(a_inverse_range, i_clk, i_rst_n, r_out_valid && r_modulus != '0, r_inverse < r_modulus, "inverse not reduced")

endmodule

// ===== hw/rtl/modular_inverse_extended_gcd_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Modular inverse core (extended Euclid)
// Computes the inverse of a word modulo a configured modulus and flags
// whether the gcd is one.
//
//   channel | direction | handshake                  | payload
//   --------+-----------+----------------------------+--------------------------
//   in      | input     | i_in_valid / o_in_ready    | i_value
//   out     | output    | o_out_valid / i_out_ready  | o_inverse, o_has_inverse
//   cfg     | input     | i_cfg_we                   | i_cfg_wdata (modulus)
//
// Each Euclid step runs a test, the restoring divider steps and an update;
// a new word is taken only in the idle state, once the last one is done.
// Reset is synchronous and active low; the modulus resets to 1.
// A result waits in the output register; the next word is taken meanwhile,
// and its result holds in the datapath until the register frees.
// ----------------------------------------------------------------------------
module modular_inverse_extended_gcd_core #(
    parameter int WIDTH = mieg_pkg::P_WIDTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [WIDTH-2:0] i_cfg_wdata,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  logic [WIDTH-2:0] i_value,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output logic [WIDTH-2:0] o_inverse,
    output logic             o_has_inverse
);
    import mieg_pkg::*;

    t_cmd    cmd;
    t_status status;

    mieg_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    mieg_dp #(
        .WIDTH (WIDTH)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_value       (i_value),
        .i_cmd         (cmd),
        .o_status      (status),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_inverse     (o_inverse),
        .o_has_inverse (o_has_inverse)
    );

endmodule
